// ===== design/wcht_pkg.sv =====
// Shared types and constants for the word count hash table.
package wcht_pkg;

   localparam int TableSlots = 4096;
   localparam int MaxWordLen = 16;
   localparam int SlotBits = $clog2(TableSlots);
   localparam int PosBits = $clog2(MaxWordLen + 2);
   localparam int EntryBits = SlotBits + 1;
   localparam int KeyAddrBits = SlotBits + $clog2(MaxWordLen);
   localparam int ProbeBits = SlotBits + 1;

   localparam logic [31:0] HashInit = 32'd2166136261;
   localparam logic [31:0] HashPrime = 32'd16777619;
   localparam logic [31:0] CntMax = 32'hFFFF_FFFF;

   localparam logic [0:0] CsrInsertEnable = 1'd0;
   localparam logic [0:0] CsrMaxEntries = 1'd1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_TOO_LONG  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SLOT_RD,
      ST_SLOT_WAIT,
      ST_SLOT_CHK,
      ST_KEY_RD,
      ST_KEY_WAIT,
      ST_KEY_CHK,
      ST_CNT_WAIT,
      ST_UPDATE,
      ST_WRITE_KEY
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic clear_step;
      logic clear_init;
      logic take_byte;
      logic probe_init;
      logic slot_read;
      logic key_init;
      logic key_read;
      logic key_next;
      logic probe_next;
      logic cnt_read;
      logic do_update;
      logic do_insert;
      logic wkey_step;
      logic rsp_fire;
      status_type rsp_status;
   } ctrl_type;

   // Datapath to controller.
   typedef struct packed {
      logic clear_done;
      logic last_byte;
      logic too_long;
      logic slot_valid;
      logic len_match;
      logic key_byte_eq;
      logic key_done;
      logic probe_done;
      logic counting;
      logic table_full;
      logic wkey_done;
   } stat_type;

endpackage

// ===== design/wcht_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module wcht_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== design/wcht_ctrl.sv =====
// Controller state machine for the word count hash table.
module wcht_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   output logic               req_busy,
   input  wcht_pkg::stat_type stat,
   output wcht_pkg::ctrl_type ctrl
);
   wcht_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wcht_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctrl = '0;
      ctrl.rsp_status = wcht_pkg::STATUS_OK;
      req_busy = 1'b1;
      unique case (state_ff)
         wcht_pkg::ST_CLEAR: begin
            ctrl.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = wcht_pkg::ST_IDLE;
            end
         end
         wcht_pkg::ST_IDLE: begin
            req_busy = 1'b0;
            if (req_start) begin
               ctrl.take_byte = 1'b1;
               if (stat.last_byte) begin
                  if (stat.too_long) begin
                     ctrl.rsp_fire = 1'b1;
                     ctrl.rsp_status = wcht_pkg::STATUS_TOO_LONG;
                  end else begin
                     ctrl.probe_init = 1'b1;
                     state_in = wcht_pkg::ST_SLOT_RD;
                  end
               end
            end
         end
         wcht_pkg::ST_SLOT_RD: begin
            ctrl.slot_read = 1'b1;
            state_in = wcht_pkg::ST_SLOT_WAIT;
         end
         wcht_pkg::ST_SLOT_WAIT: begin
            state_in = wcht_pkg::ST_SLOT_CHK;
         end
         wcht_pkg::ST_SLOT_CHK: begin
            if (!stat.slot_valid) begin
               if (!stat.counting) begin
                  ctrl.rsp_fire = 1'b1;
                  ctrl.rsp_status = wcht_pkg::STATUS_NOT_FOUND;
                  state_in = wcht_pkg::ST_IDLE;
               end else if (stat.table_full) begin
                  ctrl.rsp_fire = 1'b1;
                  ctrl.rsp_status = wcht_pkg::STATUS_FULL;
                  state_in = wcht_pkg::ST_IDLE;
               end else begin
                  ctrl.do_insert = 1'b1;
                  state_in = wcht_pkg::ST_WRITE_KEY;
               end
            end else if (stat.len_match) begin
               ctrl.key_init = 1'b1;
               state_in = wcht_pkg::ST_KEY_RD;
            end else begin
               ctrl.probe_next = 1'b1;
               state_in = wcht_pkg::ST_SLOT_RD;
            end
            if (stat.slot_valid && !stat.len_match && stat.probe_done) begin
               ctrl.probe_next = 1'b0;
               ctrl.rsp_fire = 1'b1;
               ctrl.rsp_status = stat.counting ? wcht_pkg::STATUS_FULL
                                               : wcht_pkg::STATUS_NOT_FOUND;
               state_in = wcht_pkg::ST_IDLE;
            end
         end
         wcht_pkg::ST_KEY_RD: begin
            if (stat.key_done) begin
               ctrl.cnt_read = 1'b1;
               state_in = wcht_pkg::ST_CNT_WAIT;
            end else begin
               ctrl.key_read = 1'b1;
               state_in = wcht_pkg::ST_KEY_WAIT;
            end
         end
         wcht_pkg::ST_KEY_WAIT: begin
            state_in = wcht_pkg::ST_KEY_CHK;
         end
         wcht_pkg::ST_KEY_CHK: begin
            if (stat.key_byte_eq) begin
               ctrl.key_next = 1'b1;
               state_in = wcht_pkg::ST_KEY_RD;
            end else if (stat.probe_done) begin
               ctrl.rsp_fire = 1'b1;
               ctrl.rsp_status = stat.counting ? wcht_pkg::STATUS_FULL
                                               : wcht_pkg::STATUS_NOT_FOUND;
               state_in = wcht_pkg::ST_IDLE;
            end else begin
               ctrl.probe_next = 1'b1;
               state_in = wcht_pkg::ST_SLOT_RD;
            end
         end
         wcht_pkg::ST_CNT_WAIT: begin
            state_in = wcht_pkg::ST_UPDATE;
         end
         wcht_pkg::ST_UPDATE: begin
            ctrl.do_update = 1'b1;
            ctrl.rsp_fire = 1'b1;
            state_in = wcht_pkg::ST_IDLE;
         end
         wcht_pkg::ST_WRITE_KEY: begin
            ctrl.wkey_step = 1'b1;
            if (stat.wkey_done) begin
               ctrl.rsp_fire = 1'b1;
               state_in = wcht_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wcht_pkg::ST_IDLE;
         end
      endcase
   end
endmodule

// ===== design/wcht_datapath.sv =====
// Datapath: hash, token buffer, slot/key/count memories and result registers.
module wcht_datapath (
   input  logic               clock,
   input  logic               reset,
   input  wcht_pkg::ctrl_type ctrl,
   output wcht_pkg::stat_type stat,
   input  logic [7:0]         req_byte_req,
   input  logic               req_last,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [12:0]        csr_wdata,
   output logic [11:0]        rsp_word_id,
   output logic [31:0]        rsp_count,
   output logic               rsp_new_word,
   output logic [1:0]         rsp_status,
   output logic [31:0]        rsp_tokens_seen,
   output logic               rsp_valid
);
   localparam int SB = wcht_pkg::SlotBits;
   localparam int EB = wcht_pkg::EntryBits;
   localparam int PB = wcht_pkg::PosBits;
   localparam int KB = $clog2(wcht_pkg::MaxWordLen);

   logic insert_enable_ff;
   logic [12:0] max_entries_ff;
   logic [31:0] hash_ff;
   logic [PB-1:0] pos_ff;
   logic [7:0] wbuf_ff [wcht_pkg::MaxWordLen];
   logic [PB-1:0] len_ff;
   logic [SB-1:0] slot_ff;
   logic slot_load_ff;
   logic [wcht_pkg::ProbeBits-1:0] steps_ff;
   logic [PB-1:0] kidx_ff;
   logic [EB-1:0] entry_total_ff;
   logic [31:0] token_total_ff;
   logic [SB-1:0] clr_ff;
   logic [SB-1:0] hit_entry_ff;
   logic [31:0] prod_ff;
   logic mul_pend_ff;

   logic [31:0] hash_x;
   logic [31:0] hash_new;
   logic [31:0] sext;
   logic [PB-1:0] pos_new;
   logic [31:0] tok_inc;
   logic counting;

   // slot RAM: {valid, entry id}
   logic slot_we;
   logic [SB-1:0] slot_waddr;
   logic [SB:0] slot_wdata, slot_rdata;
   logic [SB-1:0] slot_raddr;
   // length RAM
   logic [PB-1:0] klen_rdata;
   // key RAM
   logic key_we;
   logic [wcht_pkg::KeyAddrBits-1:0] key_waddr, key_raddr;
   logic [7:0] key_rdata;
   // count RAM
   logic cnt_we;
   logic [SB-1:0] cnt_waddr;
   logic [31:0] cnt_wdata, cnt_rdata;
   logic [31:0] cnt_inc;
   logic [EB-1:0] limit;
   logic [SB-1:0] slot_entry;

   assign counting = insert_enable_ff;
   assign sext = {{24{req_byte_req[7]}}, req_byte_req};
   assign hash_x = hash_ff ^ sext;
   assign pos_new = (pos_ff <= PB'(wcht_pkg::MaxWordLen)) ? pos_ff + 1'b1 : pos_ff;
   assign tok_inc = (token_total_ff != wcht_pkg::CntMax) ? token_total_ff + 1'b1
                                                        : token_total_ff;
   assign slot_entry = slot_rdata[SB-1:0];
   assign limit = (max_entries_ff < EB'(wcht_pkg::TableSlots)) ? EB'(max_entries_ff)
                                                              : EB'(wcht_pkg::TableSlots);
   assign cnt_inc = (cnt_rdata != wcht_pkg::CntMax) ? cnt_rdata + 1'b1 : cnt_rdata;

   // Byte hashing: one multiply per byte, registered; the next byte waits until the product is in hash_ff.
   assign hash_new = prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         insert_enable_ff <= 1'b1;
         max_entries_ff <= 13'd3072;
         hash_ff <= wcht_pkg::HashInit;
         pos_ff <= '0;
         entry_total_ff <= '0;
         token_total_ff <= '0;
         clr_ff <= '0;
         rsp_valid <= 1'b0;
         mul_pend_ff <= 1'b0;
         slot_load_ff <= 1'b0;
      end else begin
         rsp_valid <= ctrl.rsp_fire;
         slot_load_ff <= ctrl.probe_init;
         if (csr_we) begin
            if (csr_index == wcht_pkg::CsrInsertEnable) begin
               insert_enable_ff <= csr_wdata[0];
            end else begin
               max_entries_ff <= csr_wdata;
            end
         end
         if (ctrl.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         mul_pend_ff <= ctrl.take_byte && !req_last;
         if (mul_pend_ff) begin
            hash_ff <= hash_new;
         end
         if (ctrl.take_byte) begin
            if (req_last) begin
               hash_ff <= wcht_pkg::HashInit;
               pos_ff <= '0;
            end else begin
               pos_ff <= pos_new;
            end
            if (req_last && counting && (pos_new > PB'(wcht_pkg::MaxWordLen))) begin
               token_total_ff <= tok_inc;
            end
            if (req_last && counting && (pos_new <= PB'(wcht_pkg::MaxWordLen))) begin
               token_total_ff <= tok_inc;
            end
         end
         if (ctrl.do_insert) begin
            entry_total_ff <= entry_total_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= hash_x * wcht_pkg::HashPrime;
      if (ctrl.take_byte) begin
         if (pos_ff < PB'(wcht_pkg::MaxWordLen)) begin
            wbuf_ff[pos_ff[KB-1:0]] <= req_byte_req;
         end
         if (req_last) begin
            len_ff <= pos_new;
         end
      end
      if (ctrl.probe_init) begin
         steps_ff <= '0;
      end
      // final hash product is ready in the cycle after the last byte is taken
      if (slot_load_ff) begin
         slot_ff <= prod_ff[SB-1:0];
      end
      if (ctrl.probe_next) begin
         slot_ff <= slot_ff + 1'b1;
         steps_ff <= steps_ff + 1'b1;
      end
      if (ctrl.key_init) begin
         kidx_ff <= '0;
         hit_entry_ff <= slot_entry;
      end
      if (ctrl.key_next) begin
         kidx_ff <= kidx_ff + 1'b1;
      end
      if (ctrl.do_insert) begin
         hit_entry_ff <= entry_total_ff[SB-1:0];
         kidx_ff <= '0;
      end
      if (ctrl.wkey_step) begin
         kidx_ff <= kidx_ff + 1'b1;
      end
      if (ctrl.rsp_fire) begin
         rsp_status <= ctrl.rsp_status;
         // a too-long token answers in its accept cycle, before the total updates
         rsp_tokens_seen <= (ctrl.take_byte && counting) ? tok_inc : token_total_ff;
         if (ctrl.do_update) begin
            rsp_word_id <= 12'(hit_entry_ff);
            rsp_count <= counting ? cnt_inc : cnt_rdata;
            rsp_new_word <= 1'b0;
         end else if (ctrl.wkey_step) begin
            rsp_word_id <= 12'(hit_entry_ff);
            rsp_count <= 32'd1;
            rsp_new_word <= 1'b1;
         end else begin
            rsp_word_id <= '0;
            rsp_count <= '0;
            rsp_new_word <= 1'b0;
         end
      end
   end

   // The hash is registered in prod_ff; the last byte folds in through that register.
   // The final product drives the slot read address in the first probe cycle: see slot read address.

   always_comb begin
      slot_we = 1'b0;
      slot_waddr = slot_ff;
      slot_wdata = {1'b1, entry_total_ff[SB-1:0]};
      if (ctrl.clear_step) begin
         slot_we = 1'b1;
         slot_waddr = clr_ff;
         slot_wdata = '0;
      end else if (ctrl.do_insert) begin
         slot_we = 1'b1;
      end
   end

   assign slot_raddr = slot_load_ff ? prod_ff[SB-1:0] : slot_ff;
   assign key_we = ctrl.wkey_step;
   assign key_waddr = {hit_entry_ff, kidx_ff[KB-1:0]};
   assign key_raddr = {slot_entry, kidx_ff[KB-1:0]};
   assign cnt_we = ctrl.do_update ? counting : ctrl.do_insert;
   assign cnt_waddr = ctrl.do_insert ? entry_total_ff[SB-1:0] : hit_entry_ff;
   assign cnt_wdata = ctrl.do_insert ? 32'd1 : cnt_inc;

   wcht_ram #(.Width(SB + 1), .Depth(wcht_pkg::TableSlots)) u_slot (
      .clock(clock), .wr_en(slot_we), .wr_addr(slot_waddr), .wr_data(slot_wdata),
      .rd_addr(slot_raddr), .rd_data(slot_rdata)
   );
   wcht_ram #(.Width(PB), .Depth(wcht_pkg::TableSlots)) u_klen (
      .clock(clock), .wr_en(ctrl.do_insert), .wr_addr(entry_total_ff[SB-1:0]),
      .wr_data(len_ff), .rd_addr(slot_rdata[SB-1:0]), .rd_data(klen_rdata)
   );
   wcht_ram #(.Width(8), .Depth(wcht_pkg::TableSlots * wcht_pkg::MaxWordLen)) u_key (
      .clock(clock), .wr_en(key_we), .wr_addr(key_waddr),
      .wr_data(wbuf_ff[kidx_ff[KB-1:0]]), .rd_addr(key_raddr), .rd_data(key_rdata)
   );
   wcht_ram #(.Width(32), .Depth(wcht_pkg::TableSlots)) u_cnt (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wdata),
      .rd_addr(hit_entry_ff), .rd_data(cnt_rdata)
   );

   // klen_rdata is read out registered from slot_rdata and lags it, hence the extra wait state.
   always_comb begin
      stat = '0;
      stat.clear_done = (clr_ff == {SB{1'b1}});
      stat.last_byte = req_last;
      stat.too_long = (pos_new > PB'(wcht_pkg::MaxWordLen));
      stat.slot_valid = slot_rdata[SB];
      stat.len_match = (klen_rdata == len_ff);
      stat.key_byte_eq = (key_rdata == wbuf_ff[kidx_ff[KB-1:0]]);
      stat.key_done = (kidx_ff == len_ff);
      stat.probe_done = (steps_ff == wcht_pkg::ProbeBits'(wcht_pkg::TableSlots - 1));
      stat.counting = counting;
      stat.table_full = (entry_total_ff >= limit);
      stat.wkey_done = (kidx_ff == len_ff - 1'b1);
   end
endmodule

// ===== design/word_count_hash_table.sv =====
// Top level of the word count hash table.
// Usage: raise start with req_byte_req/req_last while busy is low; each
// transfer moves one byte of a token. Bytes are hashed one at a time (FNV-1a,
// but sign-extended); a non-final byte keeps the block busy for one cycle (hash
// multiply register). The final byte starts a linear probe of the slot table:
// each probed slot is read and checked, then its key compared one byte at a
// time; a hit then reads and updates the count, an empty slot stores a new word.
// A result appears on the rsp_ ports for one cycle with rsp_valid, the cycle
// after the controller finishes; the receiver cannot stall.
// A new one-byte word in an empty slot keeps busy high through SLOT_RD, SLOT_WAIT, SLOT_CHK and WRITE_KEY.
// csr_ writes (index 0 insert_enable, 1 max_entries) are always ready and
// should be issued only when the block is idle.
// After reset the block sweeps all 4096 slots of the slot table, one slot per
// cycle, with busy high.
module word_count_hash_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_byte_req,
   input  logic        req_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata,
   output logic        rsp_valid,
   output logic [11:0] rsp_word_id,
   output logic [31:0] rsp_count,
   output logic        rsp_new_word,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_tokens_seen
);
   wcht_pkg::ctrl_type ctrl;
   wcht_pkg::stat_type stat;
   logic busy_c;
   logic mul_busy_ff;

   assign csr_ready = 1'b1;

   // the byte after a non-final byte waits while the hash product is registered
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_busy_ff <= 1'b0;
      end else begin
         mul_busy_ff <= start && !busy && !req_last;
      end
   end
   assign busy = busy_c || mul_busy_ff;

   wcht_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_start(start && !mul_busy_ff),
      .req_busy(busy_c), .stat(stat), .ctrl(ctrl)
   );

   wcht_datapath u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .req_byte_req(req_byte_req), .req_last(req_last),
      .csr_we(csr_valid), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_word_id(rsp_word_id), .rsp_count(rsp_count), .rsp_new_word(rsp_new_word),
      .rsp_status(rsp_status), .rsp_tokens_seen(rsp_tokens_seen), .rsp_valid(rsp_valid)
   );
endmodule

// ===== tb/tb_word_count_hash_table.sv =====
// Self-checking testbench for word_count_hash_table: directed tokens, then random phases.
module tb_word_count_hash_table;

   typedef struct {
      logic [11:0]          id;
      logic [31:0]          cnt;
      logic                 nw;
      wcht_pkg::status_type st;
      logic [31:0]          ts;
   } word_rsp_type;

   typedef struct {
      logic [7:0]   b;
      logic         l;
      bit           typed;
      word_rsp_type rsp;
   } dir_row_type;

   logic        clock = 0, reset = 1, start = 0;
   logic        busy, csr_ready, rsp_valid, rsp_new_word;
   logic [7:0]  req_byte_req = '0;
   logic        req_last = 0, csr_valid = 0, csr_index = '0;
   logic [12:0] csr_wdata = '0;
   logic [11:0] rsp_word_id;
   logic [31:0] rsp_count, rsp_tokens_seen;
   logic [1:0]  rsp_status;

   word_count_hash_table dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // predictor state
   bit          slot_used [wcht_pkg::TableSlots];
   int          slot_entry [wcht_pkg::TableSlots];
   logic [7:0]  key_bytes [wcht_pkg::TableSlots][wcht_pkg::MaxWordLen];
   int          key_len [wcht_pkg::TableSlots];
   logic [31:0] entry_cnt [wcht_pkg::TableSlots];
   logic [7:0]  cur_word [wcht_pkg::MaxWordLen];
   logic [31:0] cur_hash = wcht_pkg::HashInit;
   int          cur_pos = 0;
   int          n_entries = 0;
   logic [31:0] n_tokens = 0;
   bit          counting_mode = 1;
   int          entry_limit = 3072;

   // expected results, ring of 16
   word_rsp_type exp_ring [16];
   int           exp_wr = 0, exp_rd = 0;
   dir_row_type  dir_rows [24];
   int           n_rows = 0;
   int           mismatches = 0, rsp_seen = 0, bytes_sent = 0;
   int           idle_cycles = 0;

   function automatic void add_row(input logic [7:0] b, input logic l, input bit typed,
                                   input word_rsp_type rsp);
      dir_rows[n_rows] = '{b, l, typed, rsp};
      n_rows++;
   endfunction

   function automatic bit word_lookup(input logic [7:0] b, input logic l,
                                      output word_rsp_type r);
      int slot, e, lim, steps;
      bit found, empty, same;
      found = 0;
      empty = 0;
      cur_hash = (cur_hash ^ {{24{b[7]}}, b}) * wcht_pkg::HashPrime;
      if (cur_pos < wcht_pkg::MaxWordLen) cur_word[cur_pos] = b;
      if (cur_pos <= wcht_pkg::MaxWordLen) cur_pos++;
      if (!l) return 0;
      r = '{12'd0, 32'd0, 1'b0, wcht_pkg::STATUS_OK, 32'd0};
      slot = cur_hash % wcht_pkg::TableSlots;
      cur_hash = wcht_pkg::HashInit;
      if (cur_pos > wcht_pkg::MaxWordLen) begin
         cur_pos = 0;
         if (counting_mode && n_tokens != wcht_pkg::CntMax) n_tokens++;
         r.st = wcht_pkg::STATUS_TOO_LONG;
         r.ts = n_tokens;
         return 1;
      end
      for (steps = 0; steps < wcht_pkg::TableSlots; steps++) begin
         if (!slot_used[slot]) begin
            empty = 1;
            break;
         end
         e = slot_entry[slot];
         same = key_len[e] == cur_pos;
         for (int i = 0; i < cur_pos; i++)
            if (key_bytes[e][i] != cur_word[i]) same = 0;
         if (same) begin
            found = 1;
            break;
         end
         slot = (slot + 1) % wcht_pkg::TableSlots;
      end
      if (counting_mode && n_tokens != wcht_pkg::CntMax) n_tokens++;
      if (found) begin
         e = slot_entry[slot];
         if (counting_mode && entry_cnt[e] != wcht_pkg::CntMax) entry_cnt[e]++;
         r.id = e[11:0];
         r.cnt = entry_cnt[e];
      end else if (!counting_mode) begin
         r.st = wcht_pkg::STATUS_NOT_FOUND;
      end else begin
         lim = entry_limit < wcht_pkg::TableSlots ? entry_limit : wcht_pkg::TableSlots;
         if (!empty || n_entries >= lim) begin
            r.st = wcht_pkg::STATUS_FULL;
         end else begin
            e = n_entries;
            for (int i = 0; i < cur_pos; i++) key_bytes[e][i] = cur_word[i];
            key_len[e] = cur_pos;
            entry_cnt[e] = 1;
            slot_used[slot] = 1;
            slot_entry[slot] = e;
            n_entries++;
            r.id = e[11:0];
            r.cnt = 1;
            r.nw = 1;
         end
      end
      cur_pos = 0;
      r.ts = n_tokens;
      return 1;
   endfunction

   task automatic feed_byte(input logic [7:0] b, input logic l, input bit typed,
                            input word_rsp_type tv);
      int gap;
      word_rsp_type r;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_byte_req <= b;
      req_last <= l;
      do @(posedge clock); while (busy);
      bytes_sent++;
      if (word_lookup(b, l, r)) begin
         if (typed) r = tv;
         exp_ring[exp_wr % 16] = r;
         exp_wr++;
      end
   endtask

   task automatic feed_token(input int n, input logic [7:0] w [20]);
      word_rsp_type none;
      none = '{12'd0, 32'd0, 1'b0, wcht_pkg::STATUS_OK, 32'd0};
      for (int i = 0; i < n; i++) feed_byte(w[i], i == n - 1, 0, none);
   endtask

   task automatic csr_write(input logic idx, input logic [12:0] val);
      start <= 0;
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (150) @(posedge clock);
      while (busy) @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == wcht_pkg::CsrInsertEnable) counting_mode = val[0];
      else entry_limit = val;
   endtask

   // result check; receiver never stalls
   always @(posedge clock) begin
      word_rsp_type e;
      if (!reset && rsp_valid) begin
         rsp_seen++;
         if (exp_wr == exp_rd) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
         end else begin
            e = exp_ring[exp_rd % 16];
            exp_rd++;
            if (rsp_word_id !== e.id || rsp_count !== e.cnt || rsp_new_word !== e.nw
                || rsp_status !== e.st || rsp_tokens_seen !== e.ts) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp id=%0d cnt=%0d new=%0b st=%0d tok=%0d, ",
                            "got id=%0d cnt=%0d new=%0b st=%0d tok=%0d"},
                           e.id, e.cnt, e.nw, e.st, e.ts, rsp_word_id, rsp_count,
                           rsp_new_word, rsp_status, rsp_tokens_seen);
            end
         end
      end
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= 20000) begin
            $display("watchdog expired, %0d results outstanding", exp_wr - exp_rd);
            $display("tb_word_count_hash_table: FAIL");
            $finish;
         end
      end
   end

   initial begin
      logic [7:0] pool [48][20];
      int         pool_len [48];
      logic [7:0] w [20];
      int         n, k;
      int         phase_ins [7] = '{1, 0, 1, 1, 0, 1, 1};
      int         phase_max [7] = '{4096, 4096, 8191, 1, 0, 0, 0};

      // directed: repeats, sign-extended byte, over-long token, two-byte token
      add_row(8'h00, 1, 1, '{12'd0, 32'd1, 1'b1, wcht_pkg::STATUS_OK, 32'd1});
      add_row(8'h00, 1, 1, '{12'd0, 32'd2, 1'b0, wcht_pkg::STATUS_OK, 32'd2});
      add_row(8'hFF, 1, 1, '{12'd1, 32'd1, 1'b1, wcht_pkg::STATUS_OK, 32'd3});
      for (int i = 0; i < 17; i++)
         add_row(8'h41, i == 16, i == 16,
                 '{12'd0, 32'd0, 1'b0, wcht_pkg::STATUS_TOO_LONG, 32'd4});
      add_row(8'h7F, 0, 0, '{12'd0, 32'd0, 1'b0, wcht_pkg::STATUS_OK, 32'd0});
      add_row(8'h80, 1, 0, '{12'd0, 32'd0, 1'b0, wcht_pkg::STATUS_OK, 32'd0});

      for (int i = 0; i < 48; i++) begin
         pool_len[i] = (i < 4) ? $urandom_range(17, 20) : $urandom_range(1, 16);
         if (i == 4) pool_len[i] = 16;
         for (int j = 0; j < 20; j++) pool[i][j] = $urandom_range(0, 255);
      end

      repeat (3) @(posedge clock);
      reset <= 0;
      csr_write(wcht_pkg::CsrMaxEntries, 13'd3072);
      csr_write(wcht_pkg::CsrInsertEnable, 1'b1);
      for (int i = 0; i < n_rows; i++)
         feed_byte(dir_rows[i].b, dir_rows[i].l, dir_rows[i].typed, dir_rows[i].rsp);

      for (int p = 0; p < 7; p++) begin
         csr_write(wcht_pkg::CsrInsertEnable, phase_ins[p][0]);
         // last phase leaves a few free entries so the limit is hit mid-phase
         csr_write(wcht_pkg::CsrMaxEntries,
                   (p == 6) ? 13'(n_entries + 5) : 13'(phase_max[p]));
         k = bytes_sent;
         while (bytes_sent - k < 275) begin
            if ($urandom_range(0, 9) < 8) begin
               n = $urandom_range(0, 47);
               w = pool[n];
               n = pool_len[n];
            end else begin
               n = $urandom_range(1, 20);
               for (int j = 0; j < 20; j++) w[j] = $urandom_range(0, 255);
            end
            feed_token(n, w);
         end
      end
      start <= 0;
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("%0d bytes sent, %0d results checked, %0d entries, %0d tokens counted",
               bytes_sent, rsp_seen, n_entries, n_tokens);
      $display("modes: count and lookup, entry limits 0, 1, near-full, 3072, 4096, 8191");
      if (mismatches == 0) $display("tb_word_count_hash_table: PASS");
      else begin
         $display("%0d mismatches", mismatches);
         $display("tb_word_count_hash_table: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/wcht_pkg.sv
design/wcht_ram.sv
design/wcht_ctrl.sv
design/wcht_datapath.sv
design/word_count_hash_table.sv
tb/tb_word_count_hash_table.sv
